// ----- rtl/rtti_pkg.sv -----
package rtti_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;
    localparam int ACC_W      = 64;
    localparam int CNT_W      = 8;

    // register index, taken from paddr above the byte offset
    localparam logic [0:0] REG_NUMBER_BASE = 1'b0;

    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;

    localparam logic [7:0] CH_CASE_MASK = 8'h5f;
    localparam logic [7:0] CH_MINUS     = 8'h2d;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5a;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;
    localparam logic [7:0] CH_UPPER_B   = 8'h42;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } rtti_in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [CNT_W-1:0]        length_used;
        logic                    finished;
        logic                    bad_base;
    } rtti_result_t;

    // classified character, as it travels through the queue
    typedef struct packed {
        logic               start;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               is_b;
        logic               digit_ok;
        logic [DIGIT_W-1:0] digit;
    } rtti_item_t;

    typedef enum logic [5:0] {
        PH_SIGN   = 6'b000001,
        PH_PREFIX = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_BAD    = 6'b100000
    } rtti_phase_t;

endpackage

// ----- rtl/rtti_front.sv -----
module rtti_front (
    input  rtti_pkg::rtti_in_t   in_data,
    output rtti_pkg::rtti_item_t item
);
    import rtti_pkg::*;

    logic       ascii;
    logic [7:0] upper;
    logic [7:0] dec_off;
    logic [7:0] alpha_off;

    assign ascii     = ~in_data.ch[7];
    assign upper     = in_data.ch & CH_CASE_MASK;
    assign dec_off   = in_data.ch - CH_ZERO;
    assign alpha_off = upper - CH_UPPER_A + 8'd10;

    always_comb begin
        item          = '0;
        item.start    = in_data.start_req;
        item.is_minus = (in_data.ch == CH_MINUS);
        item.is_zero  = (in_data.ch == CH_ZERO);
        item.is_x     = ascii && (upper == CH_UPPER_X);
        item.is_b     = ascii && (upper == CH_UPPER_B);
        if (ascii && in_data.ch >= CH_ZERO && in_data.ch <= CH_NINE) begin
            item.digit_ok = 1'b1;
            item.digit    = dec_off[DIGIT_W-1:0];
        end else if (ascii && upper >= CH_UPPER_A && upper <= CH_UPPER_Z) begin
            item.digit_ok = 1'b1;
            item.digit    = alpha_off[DIGIT_W-1:0];
        end
    end

endmodule

// ----- rtl/rtti_queue.sv -----
module rtti_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rtti_pkg::rtti_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output rtti_pkg::rtti_item_t pop_item
);
    import rtti_pkg::*;

    rtti_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/rtti_back.sv -----
module rtti_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rtti_pkg::BASE_W-1:0]   number_base,
    input  logic                          item_valid,
    input  rtti_pkg::rtti_item_t          item,
    output logic                          item_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rtti_pkg::rtti_result_t        m_data
);
    import rtti_pkg::*;

    rtti_phase_t       phase_reg, phase_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    rtti_result_t      m_data_reg, m_data_next;

    logic              used;
    logic              base_bad;
    logic [ACC_W-1:0]  limit;
    logic [ACC_W+5:0]  prod;
    logic [ACC_W+6:0]  mac;

    assign item_pop = item_valid && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign base_bad = (number_base != '0) && ((number_base < BASE_BIN) || (number_base > BASE_MAX));

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        used       = 1'b0;
        limit      = '0;
        prod       = '0;
        mac        = '0;

        if (item.start) begin
            phase_next = PH_SIGN;
            acc_next   = '0;
            neg_next   = 1'b0;
            base_next  = BASE_RESET;
            cnt_next   = '0;
        end

        // sign and base selection on the first character
        if (phase_next == PH_SIGN) begin
            if (base_bad) begin
                phase_next = PH_BAD;
                used       = 1'b1;
            end else begin
                if (number_base != '0) begin
                    base_next = number_base;
                end
                if (item.is_minus) begin
                    neg_next = 1'b1;
                    used     = 1'b1;
                end
                phase_next = (number_base == '0) ? PH_PREFIX : PH_DIGITS;
            end
        end

        if (!used && phase_next == PH_PREFIX) begin
            if (item.is_zero) begin
                base_next  = BASE_OCT;
                used       = 1'b1;
                phase_next = PH_ZERO;
            end else begin
                base_next  = BASE_DEC;
                phase_next = PH_DIGITS;
            end
        end

        if (!used && phase_next == PH_ZERO) begin
            if (item.is_x) begin
                base_next = BASE_HEX;
                used      = 1'b1;
            end else if (item.is_b) begin
                base_next = BASE_BIN;
                used      = 1'b1;
            end
            phase_next = PH_DIGITS;
        end

        // multiply-accumulate, clamp at the signed limit
        if (!used && phase_next == PH_DIGITS) begin
            if (base_next >= BASE_BIN && item.digit_ok && item.digit < base_next) begin
                limit = neg_next ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
                prod  = (ACC_W+6)'(acc_next) * (ACC_W+6)'(base_next);
                mac   = (ACC_W+7)'(prod) + (ACC_W+7)'(item.digit);
                if (mac > (ACC_W+7)'(limit)) begin
                    acc_next = limit;
                end else begin
                    acc_next = mac[ACC_W-1:0];
                end
                used = 1'b1;
            end else begin
                phase_next = PH_DONE;
            end
        end

        // the bad-base step marks used but consumes nothing
        if (used && phase_next != PH_BAD && cnt_next != {CNT_W{1'b1}}) begin
            cnt_next = cnt_next + CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (item_pop) begin
            m_valid_next = 1'b1;
            if (phase_next == PH_BAD) begin
                m_data_next.value       = '0;
                m_data_next.length_used = '0;
                m_data_next.finished    = 1'b1;
                m_data_next.bad_base    = 1'b1;
            end else begin
                m_data_next.value       = neg_next ? $signed(-acc_next) : $signed(acc_next);
                m_data_next.length_used = cnt_next;
                m_data_next.finished    = (phase_next == PH_DONE);
                m_data_next.bad_base    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIGN;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            base_reg    <= BASE_RESET;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (item_pop) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                cnt_reg   <= cnt_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

// ----- rtl/radix_text_to_integer_parser_unit.sv -----
// Streaming text-to-integer parser, one ASCII character per item.
// s_ channel: s_data.ch is the raw byte, s_data.start_req marks the first
// character of a new string and clears the running parse.
// m_ channel: one result per input item with the value parsed so far
// (saturated at the signed 64-bit limits), the characters consumed, a
// finished flag once a non-digit ends the number, and bad_base.
// APB port: register number_base at byte address 0 (radix 2..36, or 0 to
// pick the radix from a "0", "0x" or "0b" prefix). It is sampled on the
// first character of each string; write it only while the block is idle.
// An accepted item is written into the queue; when the back end pops it,
// its result is loaded into the output register. The block takes one item
// per cycle while the receiver keeps up; the multiply-accumulate is combinational.
// A two-entry queue sits between the classifier and the back end; when the
// receiver stalls the queue fills and s_ready drops once it holds two items.
// Reset (aresetn low, synchronous) empties the queue and output register,
// clears the parse and sets number_base to 10.
module radix_text_to_integer_parser_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rtti_pkg::rtti_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rtti_pkg::rtti_result_t              m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rtti_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rtti_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rtti_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import rtti_pkg::*;

    logic [BASE_W-1:0] number_base_reg, number_base_next;
    logic              cfg_sel;
    rtti_item_t        front_item;
    rtti_item_t        queue_item;
    logic              queue_full;
    logic              queue_valid;
    logic              queue_pop;

    // --- configuration register ---
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[CFG_ADDR_W-1:2] == REG_NUMBER_BASE);
    assign prdata  = cfg_sel ? CFG_DATA_W'(number_base_reg) : '0;

    always_comb begin
        number_base_next = number_base_reg;
        if (psel && penable && pwrite && pready && cfg_sel) begin
            number_base_next = pwdata[BASE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= BASE_RESET;
        end else begin
            number_base_reg <= number_base_next;
        end
    end

    // --- front: classify the character, push into the queue ---
    assign s_ready = ~queue_full;

    rtti_front u_front (
        .in_data (s_data),
        .item    (front_item)
    );

    // --- queue: decouple front and back so each can stall ---
    rtti_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_item  (queue_item)
    );

    // --- back: advance the parse and hold the result for the receiver ---
    rtti_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .number_base (number_base_reg),
        .item_valid  (queue_valid),
        .item        (queue_item),
        .item_pop    (queue_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
